// ----- src/ol_pkg.sv -----
// ----------------------------------------------------------------------------
// ol_pkg
// Shared constants, request codes and cell control type for the ordered list.
// ----------------------------------------------------------------------------
`default_nettype none

package ol_pkg;

   localparam int LIST_DEPTH_DEF  = 16;
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int REQ_TYPE_W      = 3;

   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_REMOVE = 3'd2,
      OP_READ   = 3'd3,
      OP_FIND   = 3'd4
   } op_type;

   // shift commands broadcast to every cell
   typedef struct packed {
      logic insert;
      logic remove;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- src/ol_req_if.sv -----
// ----------------------------------------------------------------------------
// ol_req_if
// Request channel: valid/ready handshake with operation, position and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface ol_req_if #(
   parameter int LIST_DEPTH  = ol_pkg::LIST_DEPTH_DEF,
   parameter int VALUE_WIDTH = ol_pkg::VALUE_WIDTH_DEF
);
   localparam int IDX_W = $clog2(LIST_DEPTH);

   logic                          valid;
   logic                          ready;
   logic [ol_pkg::REQ_TYPE_W-1:0] req_type;
   logic [IDX_W-1:0]              position;
   logic [VALUE_WIDTH-1:0]        item_value_in;

   modport source (output valid, output req_type, output position, output item_value_in,
                   input ready);
   modport sink   (input valid, input req_type, input position, input item_value_in,
                   output ready);
endinterface

`default_nettype wire

// ----- src/ol_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ol_rsp_if
// Response channel: valid/ready handshake with status, value, index and count.
// ----------------------------------------------------------------------------
`default_nettype none

interface ol_rsp_if #(
   parameter int LIST_DEPTH  = ol_pkg::LIST_DEPTH_DEF,
   parameter int VALUE_WIDTH = ol_pkg::VALUE_WIDTH_DEF
);
   localparam int IDX_W = $clog2(LIST_DEPTH);
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   logic                   valid;
   logic                   ready;
   logic                   ok;
   logic [VALUE_WIDTH-1:0] item_value_out;
   logic signed [IDX_W:0]  found_index;
   logic [CNT_W-1:0]       entry_count;

   modport source (output valid, output ok, output item_value_out, output found_index,
                   output entry_count, input ready);
   modport sink   (input valid, input ok, input item_value_out, input found_index,
                   input entry_count, output ready);
endinterface

`default_nettype wire

// ----- src/ol_cell.sv -----
// ----------------------------------------------------------------------------
// ol_cell
// One list slot: holds an entry, shifts from either neighbor, compares on find.
// ----------------------------------------------------------------------------
`default_nettype none

module ol_cell #(
   parameter int LIST_DEPTH  = ol_pkg::LIST_DEPTH_DEF,
   parameter int VALUE_WIDTH = ol_pkg::VALUE_WIDTH_DEF,
   parameter int INDEX       = 0
) (
   input  wire logic                                 clock,
   input  wire ol_pkg::cell_ctl_type                 ctl,
   input  wire logic [$clog2(LIST_DEPTH)-1:0]        where,
   input  wire logic [$clog2(LIST_DEPTH + 1)-1:0]    count,
   input  wire logic [VALUE_WIDTH-1:0]               left_value,
   input  wire logic [VALUE_WIDTH-1:0]               right_value,
   input  wire logic [VALUE_WIDTH-1:0]               new_value,
   output logic      [VALUE_WIDTH-1:0]               value,
   output logic                                      match
);
   import ol_pkg::*;

   localparam int IDX_W = $clog2(LIST_DEPTH);
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam logic [IDX_W-1:0] K_IDX = IDX_W'(INDEX);
   localparam logic [CNT_W-1:0] K_CNT = CNT_W'(INDEX);

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.insert) begin
         if (K_IDX == where) begin
            value_in = new_value;
         end else if (K_IDX > where && K_CNT <= count) begin
            value_in = left_value;
         end
      end else if (ctl.remove) begin
         if (K_IDX >= where && (K_CNT + CNT_W'(1)) < count) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign match = (K_CNT < count) && (value_ff == new_value);

endmodule

`default_nettype wire

// ----- src/ordered_list_insert_remove_search.sv -----
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_search
// Bounded positional list built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one request per handshake: append, insert at position,
//   remove at position, read at position or find value. rsp_if returns one
//   response per request with ok, the removed/read value, the first matching
//   index (-1 when none) and the entry count after the request.
//   A request accepted at an edge has its response registered and valid
//   from that edge on. While responses are taken, it accepts one request per
//   cycle; all cells shift or compare together in the accepting cycle, and
//   the read and find results come from an OR/priority select across cells.
//   The single response register gates acceptance: while a response waits
//   with rsp_if.ready low, req_if.ready is low; when it is taken, a new
//   request may be accepted in the same cycle.
//   Reset empties the list (count zero) and drops any pending response.
//   Full list: append and insert return ok low and change nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_insert_remove_search #(
   parameter int LIST_DEPTH  = ol_pkg::LIST_DEPTH_DEF,
   parameter int VALUE_WIDTH = ol_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   ol_req_if.sink    req_if,
   ol_rsp_if.source  rsp_if
);
   import ol_pkg::*;

   localparam int IDX_W = $clog2(LIST_DEPTH);
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);

   logic                   req_fire;
   op_type                 op;
   logic                   full;
   logic                   in_range;
   cell_ctl_type           ctl;
   logic [IDX_W-1:0]       where;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [VALUE_WIDTH-1:0] cell_value [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]  cell_match;
   logic [VALUE_WIDTH-1:0] rd_value;
   logic                   hit;
   logic [IDX_W-1:0]       hit_idx;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   ok_ff, ok_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [IDX_W:0]         found_ff, found_in;
   logic [CNT_W-1:0]       rsp_count_ff;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign op           = op_type'(req_if.req_type);
   assign full         = (count_ff == CNT_W'(LIST_DEPTH));
   assign in_range     = (CNT_W'(req_if.position) < count_ff);

   always_comb begin
      ctl   = '0;
      where = req_if.position;
      unique case (op)
         OP_APPEND: begin
            ctl.insert = req_fire && !full;
            where      = count_ff[IDX_W-1:0];
         end
         OP_INSERT: begin
            ctl.insert = req_fire && !full;
            where      = in_range ? req_if.position : count_ff[IDX_W-1:0];
         end
         OP_REMOVE: begin
            ctl.remove = req_fire && in_range;
         end
         default: begin
         end
      endcase
   end

   for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
      logic [VALUE_WIDTH-1:0] left_value;
      logic [VALUE_WIDTH-1:0] right_value;
      if (k == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_left
         assign left_value = cell_value[k-1];
      end
      if (k == LIST_DEPTH - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_right
         assign right_value = cell_value[k+1];
      end
      ol_cell #(
         .LIST_DEPTH  (LIST_DEPTH),
         .VALUE_WIDTH (VALUE_WIDTH),
         .INDEX       (k)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .where       (where),
         .count       (count_ff),
         .left_value  (left_value),
         .right_value (right_value),
         .new_value   (req_if.item_value_in),
         .value       (cell_value[k]),
         .match       (cell_match[k])
      );
   end

   always_comb begin
      rd_value = '0;
      hit      = 1'b0;
      hit_idx  = '0;
      for (int k = 0; k < LIST_DEPTH; k++) begin
         rd_value = rd_value
                  | (cell_value[k] & {VALUE_WIDTH{IDX_W'(k) == req_if.position}});
      end
      for (int k = LIST_DEPTH - 1; k >= 0; k--) begin
         if (cell_match[k]) begin
            hit     = 1'b1;
            hit_idx = IDX_W'(k);
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      ok_in    = 1'b0;
      value_in = '0;
      found_in = '1;
      unique case (op)
         OP_APPEND, OP_INSERT: begin
            ok_in = !full;
         end
         OP_REMOVE, OP_READ: begin
            ok_in    = in_range;
            value_in = in_range ? rd_value : '0;
         end
         OP_FIND: begin
            ok_in = hit;
            if (hit) begin
               found_in = {1'b0, hit_idx};
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ok_ff        <= ok_in;
         value_ff     <= value_in;
         found_ff     <= found_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.ok             = ok_ff;
   assign rsp_if.item_value_out = value_ff;
   assign rsp_if.found_index    = found_ff;
   assign rsp_if.entry_count    = rsp_count_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LIST_DEPTH))
      else $error("entry count above list depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.insert |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the list");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctl.remove |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("remove did not shrink the list");

   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |-> !req_if.ready)
      else $error("request accepted over a pending response");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !found_ff[IDX_W] |-> ok_ff)
      else $error("found index without ok");
`endif

endmodule

`default_nettype wire
